[hdl/ffha_pkg.sv]
package ffha_pkg;

    // Arena geometry.
    localparam int ARENA_GRANULES  = 4096;
    localparam int GRANULE_SHIFT   = 3;
    localparam int GRAN            = 1 << GRANULE_SHIFT;
    localparam int MIN_ARENA_BYTES = 64;

    // Widths derived from the geometry.
    localparam int IDX_W  = $clog2(ARENA_GRANULES);
    localparam int CNT_W  = IDX_W + 1;
    localparam int SZ_W   = 16;
    localparam int GS_W   = SZ_W - GRANULE_SHIFT;
    localparam int BG_W   = GS_W + 1;
    localparam int SUM_W  = SZ_W + IDX_W;

    // Result status codes.
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_NULL    = 3'd3;
    localparam logic [2:0] ST_CORRUPT = 3'd4;

    // Operation codes.
    localparam logic [1:0] KIND_ALLOC  = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_RESIZE = 2'd2;

    // Granules taken by a block of x user bytes, header included.
    function automatic logic [BG_W-1:0] blk_gran(input logic [SZ_W-1:0] x);
        logic [SZ_W:0] s;
        s = {1'b0, x} + (SZ_W+1)'(GRAN - 1);
        return BG_W'(s >> GRANULE_SHIFT) + BG_W'(1);
    endfunction

endpackage

[hdl/ffha_ram.sv]
// Simple dual-port memory: one write port, one read port with registered data.
// The read data holds while no read is enabled.
module ffha_ram #(
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[hdl/first_fit_heap_allocator.sv]
// First-fit heap allocator for one arena of 8-byte granules. Pulse start with
// kind, block_offset and request_bytes while busy is low; the word is taken at
// that edge. When the operation is done, o_done is high for exactly one cycle
// with the status, the resulting offset, the move flag and copy length, and the
// free-space figures on the result ports. The receiver cannot hold a result off,
// so it must capture the word in that cycle. A new command may be given in the
// same cycle the result shows. An operation's length varies: each hop of the
// first-fit search is a read of the link/size memories, then a step of compare
// and update; the search for the predecessor of a freed or resized block takes
// one read per hop, and every operation ends with a walk of the whole free list
// to recompute the free bytes and the largest free block. The worst case grows
// with the list length. After reset and after every write of the arena size
// register, a clearing pass over every granule rebuilds the arena; busy is high
// throughout and start is ignored. The configuration channel is always ready,
// but the arena size should be written only while the block is idle.
module first_fit_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [14:0] i_block_offset,
    input  logic [14:0] i_request_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [14:0] o_result_offset,
    output logic        o_moved,
    output logic [14:0] o_copy_bytes,
    output logic [15:0] o_avail_bytes,
    output logic [15:0] o_largest_free_bytes
);

    localparam int IDX_W = ffha_pkg::IDX_W;
    localparam int CNT_W = ffha_pkg::CNT_W;
    localparam int SZ_W  = ffha_pkg::SZ_W;
    localparam int GS_W  = ffha_pkg::GS_W;
    localparam int BG_W  = ffha_pkg::BG_W;
    localparam int SUM_W = ffha_pkg::SUM_W;
    localparam int GSH   = ffha_pkg::GRANULE_SHIFT;

    // Sequencer states.
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_LK0  = 5'd2;
    localparam logic [4:0] S_LK1  = 5'd3;
    localparam logic [4:0] S_FP0  = 5'd4;
    localparam logic [4:0] S_FP1  = 5'd5;
    localparam logic [4:0] S_FC1  = 5'd6;
    localparam logic [4:0] S_FC2  = 5'd7;
    localparam logic [4:0] S_FCNB = 5'd8;
    localparam logic [4:0] S_FCMG = 5'd9;
    localparam logic [4:0] S_FCEN = 5'd10;
    localparam logic [4:0] S_GR0  = 5'd11;
    localparam logic [4:0] S_GR1  = 5'd12;
    localparam logic [4:0] S_GR2  = 5'd13;
    localparam logic [4:0] S_AL0  = 5'd14;
    localparam logic [4:0] S_AL1  = 5'd15;
    localparam logic [4:0] S_AL2  = 5'd16;
    localparam logic [4:0] S_AL3  = 5'd17;
    localparam logic [4:0] S_ALEN = 5'd18;
    localparam logic [4:0] S_STI  = 5'd19;
    localparam logic [4:0] S_STL  = 5'd20;

    // Operation context: selects where the shared walks return to.
    localparam logic [2:0] CTX_ALLOC  = 3'd0;
    localparam logic [2:0] CTX_FREE   = 3'd1;
    localparam logic [2:0] CTX_SHRINK = 3'd2;
    localparam logic [2:0] CTX_GROW   = 3'd3;
    localparam logic [2:0] CTX_MOVE   = 3'd4;

    // Control registers.
    logic [4:0]       r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_gcount, n_gcount;
    logic             r_done, n_done;

    // Working registers.
    logic [1:0]       r_kind, n_kind;
    logic [14:0]      r_off, n_off;
    logic [14:0]      r_req, n_req;
    logic [2:0]       r_ctx, n_ctx;
    logic [IDX_W-1:0] r_g, n_g;
    logic [BG_W-1:0]  r_cur, n_cur;
    logic [BG_W-1:0]  r_need, n_need;
    logic [IDX_W-1:0] r_prev, n_prev;
    logic [IDX_W-1:0] r_p, n_p;
    logic [IDX_W-1:0] r_plink, n_plink;
    logic [SZ_W-1:0]  r_psize, n_psize;
    logic [IDX_W-1:0] r_t, n_t;
    logic [BG_W-1:0]  r_tg, n_tg;
    logic [SZ_W-1:0]  r_tsize, n_tsize;
    logic [2:0]       r_st, n_st;
    logic [14:0]      r_roff, n_roff;
    logic             r_moved, n_moved;
    logic [14:0]      r_copy, n_copy;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [SZ_W-1:0]  r_big, n_big;

    // Result word registers.
    logic [2:0]       r_o_status, n_o_status;
    logic [14:0]      r_o_roff, n_o_roff;
    logic             r_o_moved, n_o_moved;
    logic [14:0]      r_o_copy, n_o_copy;
    logic [15:0]      r_o_avail, n_o_avail;
    logic [15:0]      r_o_big, n_o_big;

    // Memory ports. All three stores are read at one shared address.
    logic             lk_we, sz_we, iu_we, rd_en;
    logic [IDX_W-1:0] lk_wa, sz_wa, iu_wa, rd_addr;
    logic [IDX_W-1:0] lk_wd;
    logic [SZ_W-1:0]  sz_wd;
    logic             iu_wd;
    logic [IDX_W-1:0] rd_link;
    logic [SZ_W-1:0]  rd_size;
    logic             rd_inuse;

    // Shared datapath terms.
    logic [CNT_W-1:0] gc_last;
    logic [GS_W-1:0]  rd_gs;
    logic [IDX_W-1:0] lk_h;
    logic [BG_W-1:0]  rd_blk;
    logic [BG_W-1:0]  req_blk;
    logic [BG_W:0]    lk_end;
    logic [BG_W-1:0]  pend;
    logic [BG_W-1:0]  tend;
    logic [SZ_W-1:0]  tg_bytes;
    logic [BG_W-1:0]  ext;
    logic [BG_W-1:0]  sp_w;
    logic [CNT_W-1:0] n_inc;
    logic [16:0]      copy_w;
    logic [15:0]      roff_w;
    logic [SUM_W-1:0] sum_acc, sum_d;
    logic [SZ_W-1:0]  big_acc, big_d;
    logic [CNT_W-1:0] cfg_gran;
    logic [SZ_W-1:0]  cfg_bytes;

    ffha_ram #(.WIDTH(IDX_W), .ADDR_W(IDX_W)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_wa),
        .i_wdata (lk_wd),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_link)
    );

    ffha_ram #(.WIDTH(SZ_W), .ADDR_W(IDX_W)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (sz_we),
        .i_waddr (sz_wa),
        .i_wdata (sz_wd),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_size)
    );

    ffha_ram #(.WIDTH(1), .ADDR_W(IDX_W)) u_inuse_ram (
        .i_clk   (i_clk),
        .i_we    (iu_we),
        .i_waddr (iu_wa),
        .i_wdata (iu_wd),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_inuse)
    );

    // The end marker only ever sits in the last granule, so it is a compare.
    assign gc_last  = r_gcount - CNT_W'(1);
    assign rd_gs    = rd_size[SZ_W-1:GSH];
    assign lk_h     = IDX_W'(r_off >> GSH) - IDX_W'(1);
    assign rd_blk   = ffha_pkg::blk_gran(rd_size);
    assign req_blk  = ffha_pkg::blk_gran(SZ_W'(r_req));
    assign lk_end   = (BG_W+1)'(r_g) + (BG_W+1)'(rd_blk);
    assign pend     = BG_W'(r_prev) + BG_W'(r_psize[SZ_W-1:GSH]);
    assign tend     = BG_W'(r_t) + BG_W'(r_tsize[SZ_W-1:GSH]);
    assign tg_bytes = SZ_W'(r_tg) << GSH;
    assign ext      = r_need - r_cur;
    assign sp_w     = BG_W'(r_p) + r_need;
    assign n_inc    = r_n + CNT_W'(1);
    assign copy_w   = 17'(r_cur - BG_W'(1)) << GSH;
    assign roff_w   = 16'(r_p + IDX_W'(1)) << GSH;
    assign sum_acc  = r_sum + SUM_W'(rd_size);
    assign big_acc  = (rd_size > r_big) ? rd_size : r_big;
    assign sum_d    = (sum_acc > SUM_W'(ffha_pkg::GRAN)) ?
                      sum_acc - SUM_W'(ffha_pkg::GRAN) : '0;
    assign big_d    = (big_acc > SZ_W'(ffha_pkg::GRAN)) ?
                      big_acc - SZ_W'(ffha_pkg::GRAN) : '0;

    // Arena size in granules, clamped to the supported range.
    assign cfg_bytes = (i_cfg_data < SZ_W'(ffha_pkg::MIN_ARENA_BYTES)) ?
                       SZ_W'(ffha_pkg::MIN_ARENA_BYTES) : i_cfg_data;
    assign cfg_gran  = ((SZ_W'(cfg_bytes >> GSH)) > SZ_W'(ffha_pkg::ARENA_GRANULES)) ?
                       CNT_W'(ffha_pkg::ARENA_GRANULES) : CNT_W'(cfg_bytes >> GSH);

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_gcount  = r_gcount;
        n_done    = 1'b0;
        n_kind    = r_kind;
        n_off     = r_off;
        n_req     = r_req;
        n_ctx     = r_ctx;
        n_g       = r_g;
        n_cur     = r_cur;
        n_need    = r_need;
        n_prev    = r_prev;
        n_p       = r_p;
        n_plink   = r_plink;
        n_psize   = r_psize;
        n_t       = r_t;
        n_tg      = r_tg;
        n_tsize   = r_tsize;
        n_st      = r_st;
        n_roff    = r_roff;
        n_moved   = r_moved;
        n_copy    = r_copy;
        n_sum     = r_sum;
        n_big     = r_big;
        n_o_status = r_o_status;
        n_o_roff   = r_o_roff;
        n_o_moved  = r_o_moved;
        n_o_copy   = r_o_copy;
        n_o_avail  = r_o_avail;
        n_o_big    = r_o_big;
        lk_we = 1'b0; lk_wa = '0; lk_wd = '0;
        sz_we = 1'b0; sz_wa = '0; sz_wd = '0;
        iu_we = 1'b0; iu_wa = '0; iu_wd = 1'b0;
        rd_en = 1'b0; rd_addr = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_off   = i_block_offset;
                    n_req   = i_request_bytes;
                    n_st    = ffha_pkg::ST_NULL;
                    n_roff  = '0;
                    n_moved = 1'b0;
                    n_copy  = '0;
                    n_state = S_STI;
                    n_ctx   = CTX_ALLOC;
                    case (i_kind)
                        ffha_pkg::KIND_ALLOC: begin
                            if (i_request_bytes != '0) begin
                                n_state = S_AL0;
                            end
                        end
                        ffha_pkg::KIND_FREE: begin
                            if (i_block_offset != '0) begin
                                n_state = S_LK0;
                                n_ctx   = CTX_FREE;
                            end
                        end
                        ffha_pkg::KIND_RESIZE: begin
                            if (i_block_offset != '0 && i_request_bytes != '0) begin
                                n_state = S_LK0;
                                n_ctx   = CTX_GROW;
                            end
                        end
                        default: begin
                            n_state = S_STI;
                        end
                    endcase
                end
            end

            S_CLR: begin
                // Sweep the in-use flags and lay down sentinel and first block.
                iu_we = 1'b1;
                iu_wa = r_n[IDX_W-1:0];
                iu_wd = 1'b0;
                if (r_n == CNT_W'(0)) begin
                    lk_we = 1'b1; lk_wa = '0; lk_wd = IDX_W'(1);
                    sz_we = 1'b1; sz_wa = '0; sz_wd = '0;
                end else if (r_n == CNT_W'(1)) begin
                    lk_we = 1'b1; lk_wa = IDX_W'(1); lk_wd = IDX_W'(gc_last);
                    sz_we = 1'b1; sz_wa = IDX_W'(1);
                    sz_wd = SZ_W'(r_gcount - CNT_W'(2)) << GSH;
                end
                n_n = n_inc;
                if (r_n == CNT_W'(ffha_pkg::ARENA_GRANULES - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_LK0: begin
                if (r_off[GSH-1:0] != '0 || lk_h == '0 || {1'b0, lk_h} >= r_gcount) begin
                    n_st    = ffha_pkg::ST_INVALID;
                    n_state = S_STI;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = lk_h;
                    n_g     = lk_h;
                    n_state = S_LK1;
                end
            end

            S_LK1: begin
                if (!rd_inuse || rd_size == '0 || lk_end > (BG_W+1)'(gc_last)) begin
                    n_st    = ffha_pkg::ST_INVALID;
                    n_state = S_STI;
                end else begin
                    n_cur  = rd_blk;
                    n_need = req_blk;
                    if (r_kind == ffha_pkg::KIND_FREE) begin
                        n_t     = r_g;
                        n_tg    = rd_blk;
                        n_state = S_FP0;
                    end else if (rd_blk == req_blk) begin
                        sz_we   = 1'b1; sz_wa = r_g; sz_wd = SZ_W'(r_req);
                        n_roff  = r_off;
                        n_st    = ffha_pkg::ST_OK;
                        n_state = S_STI;
                    end else if (rd_blk > req_blk) begin
                        n_t     = IDX_W'(BG_W'(r_g) + req_blk);
                        n_tg    = rd_blk - req_blk;
                        n_ctx   = CTX_SHRINK;
                        n_state = S_FP0;
                    end else begin
                        n_t     = r_g;
                        n_ctx   = CTX_GROW;
                        n_state = S_FP0;
                    end
                end
            end

            // Walk to the last list member whose successor is at or after r_t.
            S_FP0: begin
                n_p     = '0;
                n_n     = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = S_FP1;
            end

            S_FP1: begin
                if ({1'b0, rd_link} >= r_gcount) begin
                    n_st    = ffha_pkg::ST_CORRUPT;
                    n_state = S_STI;
                end else if (rd_link >= r_t) begin
                    n_prev  = r_p;
                    n_plink = rd_link;
                    n_psize = rd_size;
                    n_state = (r_ctx == CTX_GROW) ? S_GR0 : S_FC1;
                end else if (n_inc >= r_gcount) begin
                    n_st    = ffha_pkg::ST_CORRUPT;
                    n_state = S_STI;
                end else begin
                    n_n     = n_inc;
                    n_p     = rd_link;
                    rd_en   = 1'b1;
                    rd_addr = rd_link;
                end
            end

            // Link the freed range in, merging with the predecessor and the successor if adjacent.
            S_FC1: begin
                if (pend == BG_W'(r_t)) begin
                    sz_we   = 1'b1; sz_wa = r_prev; sz_wd = r_psize + tg_bytes;
                    n_tsize = r_psize + tg_bytes;
                    n_t     = r_prev;
                    n_state = S_FCNB;
                end else if (pend < BG_W'(r_t)) begin
                    lk_we   = 1'b1; lk_wa = r_t; lk_wd = r_plink;
                    sz_we   = 1'b1; sz_wa = r_t; sz_wd = tg_bytes;
                    n_tsize = tg_bytes;
                    n_state = S_FC2;
                end else begin
                    n_st    = ffha_pkg::ST_CORRUPT;
                    n_state = S_STI;
                end
            end

            S_FC2: begin
                lk_we   = 1'b1; lk_wa = r_prev; lk_wd = r_t;
                n_state = S_FCNB;
            end

            S_FCNB: begin
                if ({1'b0, r_plink} < r_gcount && {1'b0, r_plink} != gc_last &&
                    tend == BG_W'(r_plink)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_plink;
                    n_state = S_FCMG;
                end else begin
                    n_state = S_FCEN;
                end
            end

            S_FCMG: begin
                sz_we   = 1'b1; sz_wa = r_t; sz_wd = r_tsize + rd_size;
                lk_we   = 1'b1; lk_wa = r_t; lk_wd = rd_link;
                n_state = S_FCEN;
            end

            S_FCEN: begin
                n_st    = ffha_pkg::ST_OK;
                n_state = S_STI;
                if (r_ctx == CTX_FREE) begin
                    iu_we = 1'b1; iu_wa = r_g; iu_wd = 1'b0;
                end else if (r_ctx == CTX_SHRINK) begin
                    sz_we  = 1'b1; sz_wa = r_g; sz_wd = SZ_W'(r_req);
                    n_roff = r_off;
                end
            end

            // Grow in place when the next free block follows directly.
            S_GR0: begin
                if ({1'b0, r_plink} != gc_last &&
                    (BG_W+1)'(r_plink) == (BG_W+1)'(r_g) + (BG_W+1)'(r_cur)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_plink;
                    n_state = S_GR1;
                end else begin
                    n_ctx   = CTX_MOVE;
                    n_state = S_AL0;
                end
            end

            S_GR1: begin
                if (ext <= BG_W'(rd_gs)) begin
                    if (ext == BG_W'(rd_gs)) begin
                        lk_we   = 1'b1; lk_wa = r_prev; lk_wd = rd_link;
                        sz_we   = 1'b1; sz_wa = r_g; sz_wd = SZ_W'(r_req);
                        n_roff  = r_off;
                        n_st    = ffha_pkg::ST_OK;
                        n_state = S_STI;
                    end else begin
                        lk_we   = 1'b1;
                        lk_wa   = IDX_W'(BG_W'(r_g) + r_need);
                        lk_wd   = rd_link;
                        sz_we   = 1'b1;
                        sz_wa   = IDX_W'(BG_W'(r_g) + r_need);
                        sz_wd   = SZ_W'(BG_W'(rd_gs) - ext) << GSH;
                        n_t     = IDX_W'(BG_W'(r_g) + r_need);
                        n_state = S_GR2;
                    end
                end else begin
                    n_ctx   = CTX_MOVE;
                    n_state = S_AL0;
                end
            end

            S_GR2: begin
                lk_we   = 1'b1; lk_wa = r_prev; lk_wd = r_t;
                sz_we   = 1'b1; sz_wa = r_g; sz_wd = SZ_W'(r_req);
                n_roff  = r_off;
                n_st    = ffha_pkg::ST_OK;
                n_state = S_STI;
            end

            // First-fit search from the sentinel.
            S_AL0: begin
                n_need  = req_blk;
                n_prev  = '0;
                n_n     = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = S_AL1;
            end

            S_AL1: begin
                if ({1'b0, rd_link} >= r_gcount) begin
                    n_st    = ffha_pkg::ST_CORRUPT;
                    n_state = S_STI;
                end else if ({1'b0, rd_link} == gc_last) begin
                    n_st    = ffha_pkg::ST_NOFIT;
                    n_state = S_STI;
                end else begin
                    n_p     = rd_link;
                    rd_en   = 1'b1;
                    rd_addr = rd_link;
                    n_state = S_AL2;
                end
            end

            S_AL2: begin
                if (BG_W'(rd_gs) >= r_need) begin
                    if (BG_W'(rd_gs) == r_need) begin
                        lk_we   = 1'b1; lk_wa = r_prev; lk_wd = rd_link;
                        sz_we   = 1'b1; sz_wa = r_p; sz_wd = SZ_W'(r_req);
                        iu_we   = 1'b1; iu_wa = r_p; iu_wd = 1'b1;
                        n_state = S_ALEN;
                    end else if (sp_w >= BG_W'(r_gcount)) begin
                        n_st    = ffha_pkg::ST_CORRUPT;
                        n_state = S_STI;
                    end else begin
                        lk_we   = 1'b1; lk_wa = IDX_W'(sp_w); lk_wd = rd_link;
                        sz_we   = 1'b1; sz_wa = IDX_W'(sp_w);
                        sz_wd   = SZ_W'(BG_W'(rd_gs) - r_need) << GSH;
                        n_t     = IDX_W'(sp_w);
                        n_state = S_AL3;
                    end
                end else if (n_inc >= r_gcount) begin
                    n_st    = ffha_pkg::ST_CORRUPT;
                    n_state = S_STI;
                end else begin
                    // The read data still holds this block's link for the next hop.
                    n_n     = n_inc;
                    n_prev  = r_p;
                    n_state = S_AL1;
                end
            end

            S_AL3: begin
                lk_we   = 1'b1; lk_wa = r_prev; lk_wd = r_t;
                sz_we   = 1'b1; sz_wa = r_p; sz_wd = SZ_W'(r_req);
                iu_we   = 1'b1; iu_wa = r_p; iu_wd = 1'b1;
                n_state = S_ALEN;
            end

            S_ALEN: begin
                n_roff = roff_w[14:0];
                n_st   = ffha_pkg::ST_OK;
                if (r_ctx == CTX_MOVE) begin
                    n_moved = 1'b1;
                    n_copy  = (copy_w > 17'd32767) ? 15'h7FFF : copy_w[14:0];
                    iu_we   = 1'b1; iu_wa = r_g; iu_wd = 1'b0;
                    n_t     = r_g;
                    n_tg    = r_cur;
                    n_state = S_FP0;
                end else begin
                    n_state = S_STI;
                end
            end

            // Free-space statistics over the whole list.
            S_STI: begin
                n_t     = '0;
                n_n     = '0;
                n_sum   = '0;
                n_big   = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = S_STL;
            end

            S_STL: begin
                n_sum = sum_acc;
                n_big = big_acc;
                if (n_inc < r_gcount && {1'b0, rd_link} < r_gcount &&
                    {1'b0, rd_link} != gc_last) begin
                    n_n     = n_inc;
                    n_t     = rd_link;
                    rd_en   = 1'b1;
                    rd_addr = rd_link;
                end else begin
                    n_o_status = r_st;
                    n_o_roff   = r_roff;
                    n_o_moved  = r_moved;
                    n_o_copy   = r_copy;
                    n_o_avail  = (|sum_d[SUM_W-1:16]) ? 16'hFFFF : sum_d[15:0];
                    n_o_big    = 16'(big_d);
                    n_done     = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // An arena size write restarts the clearing pass.
        if (i_cfg_valid) begin
            n_gcount = cfg_gran;
            n_n      = '0;
            n_state  = S_CLR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_n      <= '0;
            r_gcount <= CNT_W'(ffha_pkg::ARENA_GRANULES);
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_gcount <= n_gcount;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_off      <= n_off;
        r_req      <= n_req;
        r_ctx      <= n_ctx;
        r_g        <= n_g;
        r_cur      <= n_cur;
        r_need     <= n_need;
        r_prev     <= n_prev;
        r_p        <= n_p;
        r_plink    <= n_plink;
        r_psize    <= n_psize;
        r_t        <= n_t;
        r_tg       <= n_tg;
        r_tsize    <= n_tsize;
        r_st       <= n_st;
        r_roff     <= n_roff;
        r_moved    <= n_moved;
        r_copy     <= n_copy;
        r_sum      <= n_sum;
        r_big      <= n_big;
        r_o_status <= n_o_status;
        r_o_roff   <= n_o_roff;
        r_o_moved  <= n_o_moved;
        r_o_copy   <= n_o_copy;
        r_o_avail  <= n_o_avail;
        r_o_big    <= n_o_big;
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_cfg_ready          = 1'b1;
    assign o_done               = r_done;
    assign o_status             = r_o_status;
    assign o_result_offset      = r_o_roff;
    assign o_moved              = r_o_moved;
    assign o_copy_bytes         = r_o_copy;
    assign o_avail_bytes        = r_o_avail;
    assign o_largest_free_bytes = r_o_big;

endmodule

[test/first_fit_heap_allocator_tb.sv]
module first_fit_heap_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // The block has no code for an unknown operation, so the testbench names one.
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;
    // Cycles without any accepted word before the run is declared hung. The slowest
    // case is a clearing pass over every granule or a long walk of a fragmented list.
    localparam int STALL_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 40;
    localparam int NGRAN = ffha_pkg::ARENA_GRANULES;
    localparam int GSHIFT = ffha_pkg::GRANULE_SHIFT;
    localparam int GBYTES = ffha_pkg::GRAN;

    typedef struct packed {
        logic [2:0]  status;
        logic [14:0] result_offset;
        logic        moved;
        logic [14:0] copy_bytes;
        logic [15:0] avail_bytes;
        logic [15:0] largest_free_bytes;
    } t_heap_result;

    // The scoreboard holds a private copy of the arena bookkeeping. Each accepted
    // command is played against that copy to get the result the block must give.
    class t_heap_scoreboard;
        int unsigned next_free[NGRAN];
        int unsigned blk_bytes[NGRAN];
        bit          end_mark[NGRAN];
        bit          in_use[NGRAN];
        int unsigned granules;
        t_heap_result pending[$];
        int errors;
        int checked;

        function void rebuild(logic [15:0] arena);
            int unsigned b;
            int unsigned g;
            b = (arena < ffha_pkg::MIN_ARENA_BYTES) ? ffha_pkg::MIN_ARENA_BYTES : arena;
            g = b >> GSHIFT;
            if (g > NGRAN) g = NGRAN;
            if (g < 3) g = 3;
            granules = g;
            for (int i = 0; i < NGRAN; i++) begin
                next_free[i] = 0;
                blk_bytes[i] = 0;
                end_mark[i]  = 0;
                in_use[i]    = 0;
            end
            next_free[0] = 1;
            next_free[1] = g - 1;
            blk_bytes[1] = (g - 2) << GSHIFT;
            end_mark[g - 1] = 1;
        endfunction

        function int unsigned span(int unsigned i);
            return blk_bytes[i] >> GSHIFT;
        endfunction

        function int unsigned granules_for(int unsigned req);
            return ((req + GBYTES - 1) >> GSHIFT) + 1;
        endfunction

        // Last free-list member whose successor is at or after granule t.
        function bit walk_to(int unsigned t, output int unsigned prev);
            int unsigned p;
            int unsigned nx;
            p = 0;
            prev = 0;
            for (int unsigned n = 0; n < granules; n++) begin
                nx = next_free[p];
                if (nx >= granules) return 0;
                if (nx >= t) begin
                    prev = p;
                    return 1;
                end
                p = nx;
            end
            return 0;
        endfunction

        function logic [2:0] release_span(int unsigned t, int unsigned tg);
            int unsigned prev;
            int unsigned pend;
            int unsigned nx;
            if (!walk_to(t, prev)) return ffha_pkg::ST_CORRUPT;
            pend = prev + span(prev);
            if (pend == t) begin
                blk_bytes[prev] += tg << GSHIFT;
                t = prev;
            end else if (pend < t) begin
                next_free[t] = next_free[prev];
                blk_bytes[t] = tg << GSHIFT;
                next_free[prev] = t;
            end else begin
                return ffha_pkg::ST_CORRUPT;
            end
            nx = next_free[t];
            if (nx < granules && !end_mark[nx] && t + span(t) == nx) begin
                blk_bytes[t] += blk_bytes[nx];
                next_free[t] = next_free[nx];
            end
            return ffha_pkg::ST_OK;
        endfunction

        function logic [2:0] carve(int unsigned req, output int unsigned off);
            int unsigned need;
            int unsigned prev;
            int unsigned p;
            int unsigned sp;
            need = granules_for(req);
            prev = 0;
            off = 0;
            for (int unsigned n = 0; n < granules; n++) begin
                p = next_free[prev];
                if (p >= granules) return ffha_pkg::ST_CORRUPT;
                if (end_mark[p]) return ffha_pkg::ST_NOFIT;
                if (span(p) >= need) begin
                    if (span(p) == need) begin
                        next_free[prev] = next_free[p];
                    end else begin
                        sp = p + need;
                        if (sp >= granules) return ffha_pkg::ST_CORRUPT;
                        next_free[sp] = next_free[p];
                        blk_bytes[sp] = (span(p) - need) << GSHIFT;
                        next_free[prev] = sp;
                    end
                    blk_bytes[p] = req;
                    in_use[p] = 1;
                    off = (p + 1) << GSHIFT;
                    return ffha_pkg::ST_OK;
                end
                prev = p;
            end
            return ffha_pkg::ST_CORRUPT;
        endfunction

        // Header granule and size in granules of a live block, if off names one.
        function bit find_live(int unsigned off, output int unsigned h, output int unsigned cur);
            h = 0;
            cur = 0;
            if ((off & (GBYTES - 1)) != 0) return 0;
            h = (off >> GSHIFT) - 1;
            if (h < 1 || h >= granules) return 0;
            if (!in_use[h] || blk_bytes[h] == 0) return 0;
            cur = granules_for(blk_bytes[h]);
            if (h + cur > granules - 1) return 0;
            return 1;
        endfunction

        function logic [2:0] resize(int unsigned off, int unsigned req, inout t_heap_result r);
            int unsigned g, cur, need, prev, nx, ext, sp, roff, cp;
            logic [2:0] st;
            if (!find_live(off, g, cur)) return ffha_pkg::ST_INVALID;
            need = granules_for(req);
            if (cur >= need) begin
                // Same size or a shrink: the tail goes back onto the list.
                if (cur > need) begin
                    st = release_span(g + need, cur - need);
                    if (st != ffha_pkg::ST_OK) return st;
                end
                blk_bytes[g] = req;
                r.result_offset = 15'(off);
                return ffha_pkg::ST_OK;
            end
            ext = need - cur;
            if (!walk_to(g, prev)) return ffha_pkg::ST_CORRUPT;
            nx = next_free[prev];
            if (!end_mark[nx] && nx == g + cur && ext <= span(nx)) begin
                // Grow in place into the free block right behind.
                if (ext == span(nx)) begin
                    next_free[prev] = next_free[nx];
                end else begin
                    sp = g + need;
                    next_free[sp] = next_free[nx];
                    blk_bytes[sp] = (span(nx) - ext) << GSHIFT;
                    next_free[prev] = sp;
                end
                blk_bytes[g] = req;
                r.result_offset = 15'(off);
                return ffha_pkg::ST_OK;
            end
            st = carve(req, roff);
            if (st != ffha_pkg::ST_OK) return st;
            r.result_offset = 15'(roff);
            r.moved = 1'b1;
            cp = (cur - 1) << GSHIFT;
            r.copy_bytes = 15'((cp > 32767) ? 32767 : cp);
            in_use[g] = 0;
            return release_span(g, cur);
        endfunction

        function t_heap_result note_input(logic [1:0] kind, int unsigned off, int unsigned req);
            t_heap_result r;
            int unsigned roff, g, cur, sum, big, t;
            r = '0;
            r.status = ffha_pkg::ST_NULL;
            if (kind == ffha_pkg::KIND_ALLOC) begin
                if (req != 0) begin
                    r.status = carve(req, roff);
                    if (r.status == ffha_pkg::ST_OK) r.result_offset = 15'(roff);
                end
            end else if (kind == ffha_pkg::KIND_FREE) begin
                if (off != 0) begin
                    if (!find_live(off, g, cur)) begin
                        r.status = ffha_pkg::ST_INVALID;
                    end else begin
                        r.status = release_span(g, cur);
                        if (r.status == ffha_pkg::ST_OK) in_use[g] = 0;
                    end
                end
            end else if (kind == ffha_pkg::KIND_RESIZE) begin
                if (off != 0 && req != 0) begin
                    r.status = resize(off, req, r);
                    if (r.status != ffha_pkg::ST_OK && r.moved == 1'b0) r.result_offset = '0;
                end
            end
            // Free figures after the operation, one header less, floored at zero.
            sum = 0;
            big = 0;
            t = 0;
            for (int unsigned n = 0; n < granules && t < granules && !end_mark[t]; n++) begin
                sum += blk_bytes[t];
                if (blk_bytes[t] > big) big = blk_bytes[t];
                t = next_free[t];
            end
            sum = (sum > GBYTES) ? sum - GBYTES : 0;
            big = (big > GBYTES) ? big - GBYTES : 0;
            r.avail_bytes = 16'((sum > 32'hFFFF) ? 32'hFFFF : sum);
            r.largest_free_bytes = 16'((big > 32'hFFFF) ? 32'hFFFF : big);
            pending.push_back(r);
            return r;
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(t_heap_result got);
            t_heap_result want;
            if (pending.size() == 0) begin
                report_mismatch("result word with none outstanding", got.status, 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.result_offset !== want.result_offset)
                report_mismatch("result_offset", got.result_offset, want.result_offset);
            if (got.moved !== want.moved)
                report_mismatch("moved", got.moved, want.moved);
            if (got.copy_bytes !== want.copy_bytes)
                report_mismatch("copy_bytes", got.copy_bytes, want.copy_bytes);
            if (got.avail_bytes !== want.avail_bytes)
                report_mismatch("avail_bytes", got.avail_bytes, want.avail_bytes);
            if (got.largest_free_bytes !== want.largest_free_bytes)
                report_mismatch("largest_free_bytes", got.largest_free_bytes,
                                want.largest_free_bytes);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [14:0] i_block_offset;
    logic [14:0] i_request_bytes;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        o_done;
    logic [2:0]  o_status;
    logic [14:0] o_result_offset;
    logic        o_moved;
    logic [14:0] o_copy_bytes;
    logic [15:0] o_avail_bytes;
    logic [15:0] o_largest_free_bytes;

    first_fit_heap_allocator dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_kind              (i_kind),
        .i_block_offset      (i_block_offset),
        .i_request_bytes     (i_request_bytes),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_result_offset     (o_result_offset),
        .o_moved             (o_moved),
        .o_copy_bytes        (o_copy_bytes),
        .o_avail_bytes       (o_avail_bytes),
        .o_largest_free_bytes(o_largest_free_bytes)
    );

    t_heap_scoreboard heap_sb = new();

    // User offsets of the blocks the scoreboard believes are live. Frees and
    // resizes mostly pick from here, so the random part walks deep into the list.
    int unsigned live_blocks[$];
    int idle_pct;
    int words_sent;
    int stall_cycles;
    int arenas_done;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Every result word is on the ports for one cycle only and is taken at the
    // rising edge that closes that cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            heap_sb.check_result({o_status, o_result_offset, o_moved, o_copy_bytes,
                                  o_avail_bytes, o_largest_free_bytes});
        end
    end

    // The watchdog only counts cycles in which no word of any kind moves.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
                $display("first_fit_heap_allocator: mismatch");
                $finish;
            end
        end
    end

    // Called right after a falling edge; drops start at the next falling edge that
    // follows acceptance and returns then or after a random idle wait.
    task automatic send_cmd(logic [1:0] kind, logic [14:0] off, logic [14:0] req);
        t_heap_result r;
        int idx;
        start = 1'b1;
        i_kind = kind;
        i_block_offset = off;
        i_request_bytes = req;
        do @(posedge i_clk); while (busy);
        r = heap_sb.note_input(kind, off, req);
        words_sent++;
        // Keep the list of live blocks in step with what the block should have done.
        if (r.status == ffha_pkg::ST_OK) begin
            if (kind == ffha_pkg::KIND_ALLOC) begin
                live_blocks.push_back(r.result_offset);
            end else if (kind == ffha_pkg::KIND_FREE ||
                         (kind == ffha_pkg::KIND_RESIZE && r.moved)) begin
                idx = -1;
                foreach (live_blocks[i]) if (live_blocks[i] == off) idx = i;
                if (idx >= 0) live_blocks.delete(idx);
                if (kind == ffha_pkg::KIND_RESIZE) live_blocks.push_back(r.result_offset);
            end
        end
        @(negedge i_clk);
        start = 1'b0;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
    endtask

    // The arena size is only changed once every outstanding result has come back.
    task automatic write_arena(logic [15:0] arena);
        while (heap_sb.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = arena;
        do @(posedge i_clk); while (!o_cfg_ready);
        heap_sb.rebuild(arena);
        live_blocks.delete();
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        arenas_done++;
    endtask

    function automatic logic [14:0] pick_size();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) return 15'($urandom_range(1, 64));
        if (roll < 95) return 15'($urandom_range(65, 1024));
        return 15'($urandom_range(1025, 32767));
    endfunction

    function automatic logic [14:0] pick_live();
        return 15'(live_blocks[$urandom_range(live_blocks.size() - 1)]);
    endfunction

    task automatic random_cmd();
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            // Noise: any kind with raw offsets and sizes, zero and misaligned included.
            send_cmd(2'($urandom_range(3)), 15'($urandom()),
                     ($urandom_range(3) == 0) ? 15'd0 : 15'($urandom()));
        end else if (live_blocks.size() == 0 || roll < 50) begin
            send_cmd(ffha_pkg::KIND_ALLOC, '0, pick_size());
        end else if (roll < 78) begin
            send_cmd(ffha_pkg::KIND_FREE, pick_live(), 15'($urandom()));
        end else begin
            send_cmd(ffha_pkg::KIND_RESIZE, pick_live(), pick_size());
        end
    endtask

    logic [15:0] arena_plan[7] = '{16'd64, 16'd0, 16'd100, 16'd1024, 16'd4096,
                                   16'hFFFF, 16'd32768};
    logic [14:0] blk_a;
    logic [14:0] blk_b;

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_kind = ffha_pkg::KIND_ALLOC;
        i_block_offset = '0;
        i_request_bytes = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        idle_pct = 0;
        words_sent = 0;
        arenas_done = 0;
        stall_cycles = 0;
        heap_sb.rebuild(16'd32768);
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed checks on the reset arena: the null and unknown cases, bad
        // offsets, the largest request, and each way a resize can go.
        send_cmd(ffha_pkg::KIND_ALLOC, '0, 15'd0);
        send_cmd(KIND_UNKNOWN, 15'd8, 15'd8);
        send_cmd(ffha_pkg::KIND_FREE, '0, 15'd8);
        send_cmd(ffha_pkg::KIND_RESIZE, 15'd16, 15'd0);
        send_cmd(ffha_pkg::KIND_ALLOC, '0, 15'd32767);
        send_cmd(ffha_pkg::KIND_ALLOC, '0, 15'd1);
        blk_a = 15'(live_blocks[0]);
        send_cmd(ffha_pkg::KIND_ALLOC, '0, 15'd40);
        blk_b = 15'(live_blocks[1]);
        send_cmd(ffha_pkg::KIND_FREE, blk_a + 15'd3, '0);
        send_cmd(ffha_pkg::KIND_FREE, 15'h7FF8, '0);
        send_cmd(ffha_pkg::KIND_RESIZE, blk_b, 15'd40);
        send_cmd(ffha_pkg::KIND_RESIZE, blk_b, 15'd200);
        send_cmd(ffha_pkg::KIND_RESIZE, blk_b, 15'd16);
        send_cmd(ffha_pkg::KIND_RESIZE, blk_a, 15'd100);
        blk_a = 15'(live_blocks[$]);
        send_cmd(ffha_pkg::KIND_FREE, blk_b, '0);
        send_cmd(ffha_pkg::KIND_FREE, blk_b, '0);
        send_cmd(ffha_pkg::KIND_RESIZE, blk_a, 15'd32767);
        send_cmd(ffha_pkg::KIND_FREE, blk_a, '0);

        // Random phases, one per arena size, cycling through the sender idle rates.
        foreach (arena_plan[p]) begin
            write_arena(arena_plan[p]);
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 58;
                default: idle_pct = 25;
            endcase
            repeat (83) random_cmd();
        end

        while (heap_sb.pending.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Sent %0d commands over %0d arena sizes; %0d results checked.",
                 words_sent, arenas_done + 1, heap_sb.checked);
        if (heap_sb.errors == 0) begin
            $display("first_fit_heap_allocator: match");
        end else begin
            $display("%0d field mismatches.", heap_sb.errors);
            $display("first_fit_heap_allocator: mismatch");
        end
        $finish;
    end

endmodule
